FILE: sv/key_value_command_parser_core_macros.svh
// ----------------------------------------------------------------------------
// key_value_command_parser_core_macros
// assertion macros shared by the command parser rtl
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_COMMAND_PARSER_CORE_MACROS_SVH
`define KEY_VALUE_COMMAND_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define KVCP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kvcp assertion failed");

// next-cycle implication, checked outside reset
`define KVCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kvcp assertion failed");

`else

`define KVCP_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define KVCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/kvcp_pkg.sv
// ----------------------------------------------------------------------------
// kvcp_pkg
// types, key names and codes for the key/value command parser
// ----------------------------------------------------------------------------
package kvcp_pkg;

  localparam int unsigned NAME_COUNT   = 5;
  localparam int unsigned NAME_MAX_LEN = 8;
  localparam int unsigned NAME_POS_W   = 3;
  localparam int unsigned MAG_W        = 32;

  // saturation point of the magnitude, just above the negative limit
  localparam logic [MAG_W-1:0] MAG_CAP     = 32'h8000_0001;
  localparam logic [MAG_W-1:0] MAG_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [MAG_W-1:0] MAG_NEG_MAX = 32'h8000_0000;

  localparam logic [7:0] NAME_CHARS [NAME_COUNT][NAME_MAX_LEN] = '{
    '{"t", "e", "m", "p", "_", "s", "e", "t"},
    '{"p", "u", "b", "_", "r", "a", "t", "e"},
    '{"s", "o", "m", "e", "1", 8'h00, 8'h00, 8'h00},
    '{"s", "o", "m", "e", "2", 8'h00, 8'h00, 8'h00},
    '{"s", "o", "m", "e", "3", 8'h00, 8'h00, 8'h00}
  };
  localparam int unsigned NAME_LEN [NAME_COUNT] = '{8, 8, 5, 5, 5};

  // byte codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    ST_UPDATED      = 2'd0,
    ST_UNKNOWN_KEY  = 2'd1,
    ST_BAD_NUMBER   = 2'd2,
    ST_KEY_TOO_LONG = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_KEY   = 3'b001,
    PH_VALUE = 3'b010,
    PH_SKIP  = 3'b100
  } phase_t;

endpackage

FILE: sv/key_value_command_parser_core.sv
// ----------------------------------------------------------------------------
// key_value_command_parser_core
// byte-stream parser for "key:value" tokens; updates a small value table
// and reports slot, value and status for every token that holds a colon
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  in_      | in        | in_valid / in_stall  | char_byte, end_of_message
//  out_     | out       | out_valid / out_stall| slot, new_value, status
//
// one byte is taken every cycle while in_stall is low; its result, if any, goes
// to the output register, or to the skid entry if the output is held. the token
// state (key compare mask, key length, decimal accumulator) advances by one
// small update per byte, which sets the rate. synchronous active-low reset
// clears the token state and the value table. the result side has an output
// register plus one skid entry; in_stall rises only while that entry is occupied.
//
`include "key_value_command_parser_core_macros.svh"

module key_value_command_parser_core #(
  parameter int unsigned KEY_SLOTS = 5,
  parameter int unsigned KEY_LIMIT = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_char_byte,
  input  logic                     in_end_of_message,
  // result output
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_slot,
  output logic signed [31:0]       out_new_value,
  output kvcp_pkg::status_t        out_status
);

  import kvcp_pkg::*;

  localparam int unsigned KL_W   = $clog2(KEY_LIMIT + 1);
  localparam int unsigned SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  // token state
  phase_t                  phase_r, phase_nxt;
  logic [KL_W-1:0]         key_len_r, key_len_nxt;
  logic [NAME_COUNT-1:0]   key_mask_r, key_mask_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  logic                    digit_seen_r, digit_seen_nxt;
  logic                    number_bad_r, number_bad_nxt;
  logic                    sign_seen_r, sign_seen_nxt;

  logic signed [31:0]      value_table_r [KEY_SLOTS];

  // output register and skid entry
  logic                    out_valid_r;
  logic [2:0]              out_slot_r;
  logic signed [31:0]      out_value_r;
  status_t                 out_status_r;
  logic                    skid_valid_r;
  logic [2:0]              skid_slot_r;
  logic signed [31:0]      skid_value_r;
  status_t                 skid_status_r;

  // per-byte combinational values
  logic                    in_fire;
  logic                    is_nul, is_delim, is_blank, is_digit, is_sign, is_last;
  logic                    apply_byte;
  logic [35:0]             mag_times10;
  logic [NAME_POS_W-1:0]   name_pos;
  logic                    pos_in_range;
  logic [31:0]             key_len_ext;
  logic                    ends_token;
  logic                    res_fire;
  logic [2:0]              res_slot;
  logic signed [31:0]      res_value;
  status_t                 res_status;
  logic                    key_found;
  logic [MAG_W-1:0]        mag_limit;

  assign in_fire  = in_valid && !skid_valid_r;
  assign in_stall = skid_valid_r;

  assign is_nul   = (in_char_byte == CH_NUL);
  assign is_delim = (in_char_byte == CH_COMMA) || (in_char_byte == CH_LBRACE) ||
                    (in_char_byte == CH_RBRACE);
  assign is_blank = (in_char_byte == CH_SPACE) ||
                    ((in_char_byte >= CH_TAB) && (in_char_byte <= CH_CR));
  assign is_digit = (in_char_byte >= CH_ZERO) && (in_char_byte <= CH_NINE);
  assign is_sign  = (in_char_byte == CH_PLUS) || (in_char_byte == CH_MINUS);
  assign is_last  = in_end_of_message;

  // only ordinary bytes outside a skipped message change the token
  assign apply_byte = (phase_r != PH_SKIP) && !is_nul && !is_delim && !is_blank;

  // x10 by shift and add; magnitude is capped so 36 bits hold the sum
  assign mag_times10 = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0}
                     + {28'd0, in_char_byte - CH_ZERO};

  assign key_len_ext  = 32'(key_len_r);
  assign pos_in_range = key_len_ext < NAME_MAX_LEN;
  assign name_pos     = key_len_ext[NAME_POS_W-1:0];

  // token state update for this byte (before any token end)
  logic [MAG_W-1:0]        upd_mag;
  phase_t                  upd_phase;
  logic [KL_W-1:0]         upd_key_len;
  logic [NAME_COUNT-1:0]   upd_mask;
  logic                    upd_neg, upd_digit, upd_bad, upd_sign;

  always_comb begin
    upd_phase   = phase_r;
    upd_key_len = key_len_r;
    upd_mask    = key_mask_r;
    upd_mag     = mag_r;
    upd_neg     = neg_r;
    upd_digit   = digit_seen_r;
    upd_bad     = number_bad_r;
    upd_sign    = sign_seen_r;
    if (apply_byte) begin
      if (phase_r == PH_KEY) begin
        if (in_char_byte == CH_COLON) begin
          upd_phase = PH_VALUE;
        end else if (key_len_r < KL_W'(KEY_LIMIT)) begin
          // drop every name that this byte no longer follows
          for (int i = 0; i < NAME_COUNT; i++) begin
            if (!pos_in_range || (key_len_ext >= NAME_LEN[i]) ||
                (NAME_CHARS[i][name_pos] != in_char_byte)) begin
              upd_mask[i] = 1'b0;
            end
          end
          upd_key_len = key_len_r + KL_W'(1);
        end
      end else begin
        if (is_digit) begin
          upd_mag   = (mag_times10 > 36'(MAG_CAP)) ? MAG_CAP : mag_times10[MAG_W-1:0];
          upd_digit = 1'b1;
        end else if (is_sign && !digit_seen_r && !sign_seen_r) begin
          upd_sign = 1'b1;
          upd_neg  = (in_char_byte == CH_MINUS);
        end else begin
          upd_bad = 1'b1;
        end
      end
    end
  end

  // token end: delimiter, byte zero or last byte of the message
  assign ends_token = (phase_r != PH_SKIP) && (is_nul || is_delim || is_last);
  assign res_fire   = in_fire && ends_token && (upd_phase == PH_VALUE);
  assign mag_limit  = upd_neg ? MAG_NEG_MAX : MAG_POS_MAX;

  // result of the finished token; first matching name of exact length wins
  always_comb begin
    res_slot  = 3'd0;
    res_value = '0;
    key_found = 1'b0;
    for (int i = NAME_COUNT - 1; i >= 0; i--) begin
      if ((i < KEY_SLOTS) && upd_mask[i] && (32'(upd_key_len) == NAME_LEN[i])) begin
        res_slot  = 3'(i);
        key_found = 1'b1;
      end
    end
    if (upd_key_len >= KL_W'(KEY_LIMIT)) begin
      res_status = ST_KEY_TOO_LONG;
      res_slot   = 3'd0;
    end else if (!key_found) begin
      res_status = ST_UNKNOWN_KEY;
    end else if (!upd_digit || upd_bad || (upd_mag > mag_limit)) begin
      res_status = ST_BAD_NUMBER;
    end else begin
      res_status = ST_UPDATED;
      res_value  = upd_neg ? -$signed(upd_mag) : $signed(upd_mag);
    end
  end

  // next token state
  always_comb begin
    phase_nxt      = upd_phase;
    key_len_nxt    = upd_key_len;
    key_mask_nxt   = upd_mask;
    mag_nxt        = upd_mag;
    neg_nxt        = upd_neg;
    digit_seen_nxt = upd_digit;
    number_bad_nxt = upd_bad;
    sign_seen_nxt  = upd_sign;
    if ((phase_r == PH_SKIP && is_last) || ends_token) begin
      phase_nxt      = PH_KEY;
      key_len_nxt    = '0;
      key_mask_nxt   = '1;
      mag_nxt        = '0;
      neg_nxt        = 1'b0;
      digit_seen_nxt = 1'b0;
      number_bad_nxt = 1'b0;
      sign_seen_nxt  = 1'b0;
      // byte zero mid-message: ignore the rest until the message ends
      if (phase_r != PH_SKIP && is_nul && !is_last) begin
        phase_nxt = PH_SKIP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_KEY;
      key_len_r    <= '0;
      key_mask_r   <= '1;
      mag_r        <= '0;
      neg_r        <= 1'b0;
      digit_seen_r <= 1'b0;
      number_bad_r <= 1'b0;
      sign_seen_r  <= 1'b0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      key_len_r    <= key_len_nxt;
      key_mask_r   <= key_mask_nxt;
      mag_r        <= mag_nxt;
      neg_r        <= neg_nxt;
      digit_seen_r <= digit_seen_nxt;
      number_bad_r <= number_bad_nxt;
      sign_seen_r  <= sign_seen_nxt;
    end
  end

  // value table, written on a successful update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        value_table_r[i] <= '0;
      end
    end else if (res_fire && (res_status == ST_UPDATED)) begin
      value_table_r[res_slot[SLOT_W-1:0]] <= res_value;
    end
  end

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || !out_stall) begin
        // output slot free this cycle: skid first, else the new result
        out_valid_r  <= skid_valid_r || res_fire;
        skid_valid_r <= 1'b0;
      end else if (res_fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_slot_r   <= skid_slot_r;
        out_value_r  <= skid_value_r;
        out_status_r <= skid_status_r;
      end else begin
        out_slot_r   <= res_slot;
        out_value_r  <= res_value;
        out_status_r <= res_status;
      end
    end
    if (res_fire) begin
      skid_slot_r   <= res_slot;
      skid_value_r  <= res_value;
      skid_status_r <= res_status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_slot      = out_slot_r;
  assign out_new_value = out_value_r;
  assign out_status    = out_status_r;

  // skid entry is only ever filled behind a held result
  `KVCP_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  // only an update carries a nonzero value
  `KVCP_ASSERT_SAME(a_value_zero_unless_updated, clk, rst_n,
    out_valid_r && (out_status_r != ST_UPDATED), out_value_r == 32'sd0)
  // key length saturates at the limit
  `KVCP_ASSERT_SAME(a_key_len_bounded, clk, rst_n, 1'b1, key_len_r <= KL_W'(KEY_LIMIT))
  // a reported update lands in the value table
  `KVCP_ASSERT_NEXT(a_table_written, clk, rst_n,
    res_fire && (res_status == ST_UPDATED),
    value_table_r[$past(res_slot[SLOT_W-1:0])] == $past(res_value))

endmodule
